// ----- src/pg3_pkg.sv -----
`timescale 1ns / 1ps

package pg3_pkg;

    // Line store geometry and field widths.
    localparam int LINE_DEPTH = 1024;
    localparam int COL_W      = $clog2(LINE_DEPTH);
    localparam int ROW_W      = 12;
    localparam int PIX_W      = 8;
    localparam int WIDTH_W    = 11;
    localparam int HEIGHT_W   = 13;
    localparam int CFG_W      = HEIGHT_W;
    localparam int MAX_HEIGHT = 4096;

    // Sums of a 3x3 window lie in -765..765.
    localparam int SUM_W  = 11;
    localparam int SQ_W   = 20;
    localparam int M4_W   = SQ_W + 3;
    localparam int DIFF_W = 8;
    localparam int MAG_W  = 7;
    localparam int STEP_W = $clog2(MAG_W);

    // Divide by three: floor(t / 3) == (t * 683) >> 11 for t below 2048.
    localparam int DIV3_BIAS  = 901;
    localparam int DIV3_OFS   = 300;
    localparam int DIV3_RECIP = 683;
    localparam int DIV3_SHIFT = 11;

    // Configuration register indexes.
    localparam logic CFG_IMAGE_WIDTH  = 1'b0;
    localparam logic CFG_IMAGE_HEIGHT = 1'b1;

    typedef struct packed {
        logic [PIX_W-1:0] upper;
        logic [PIX_W-1:0] lower;
    } t_line_word;

    typedef struct packed {
        logic             done;
        logic [MAG_W-1:0] mag;
    } t_root_status;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_SQUARE,
        ST_SUM,
        ST_ROOT,
        ST_DONE
    } t_state;

    // round(s / 3), saturated to a signed byte.
    function automatic logic signed [DIFF_W-1:0] div3_sat(input logic signed [SUM_W-1:0] s);
        logic [SUM_W:0]             t;
        logic [SUM_W+10:0]          prod;
        logic [9:0]                 q;
        logic signed [SUM_W-1:0]    qs;
        logic signed [DIFF_W-1:0]   res;
        t    = {s[SUM_W-1], s} + (SUM_W+1)'(DIV3_BIAS);
        prod = (SUM_W+11)'(t) * (SUM_W+11)'(DIV3_RECIP);
        q    = prod[DIV3_SHIFT+9:DIV3_SHIFT];
        qs   = $signed({1'b0, q}) - $signed(SUM_W'(DIV3_OFS));
        if (qs > $signed(SUM_W'(127))) begin
            res = 8'sd127;
        end else if (qs < -$signed(SUM_W'(128))) begin
            res = -8'sd128;
        end else begin
            res = qs[DIFF_W-1:0];
        end
        return res;
    endfunction

endpackage

// ----- src/pg3_line_ram.sv -----
`timescale 1ns / 1ps

// Both line stores share one word: the upper half holds the older line.
module pg3_line_ram
    import pg3_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rd_en,
    input  logic [COL_W-1:0] i_rd_addr,
    output t_line_word       o_rd_data,
    input  logic             i_wr_en,
    input  logic [COL_W-1:0] i_wr_addr,
    input  t_line_word       i_wr_data
);

    t_line_word mem [LINE_DEPTH];
    t_line_word r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- src/pg3_mag_root.sv -----
`timescale 1ns / 1ps

// Finds the largest n with (6n-3)^2 <= m4, one result bit per cycle, MSB first.
module pg3_mag_root
    import pg3_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  logic [M4_W-1:0] i_m4,
    output t_root_status    o_status
);

    logic [M4_W-1:0]   r_m4;
    logic [MAG_W-1:0]  r_n;
    logic [STEP_W-1:0] r_step;
    logic              r_busy;
    logic              r_done;

    logic [MAG_W-1:0]  trial;
    logic [9:0]        odd;
    logic [19:0]       odd_sq;

    always_comb begin
        trial  = r_n | (MAG_W'(1) << r_step);
        odd    = {trial, 2'b00} + {1'b0, trial, 1'b0} - 10'd3;
        odd_sq = 20'(odd) * 20'(odd);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= r_busy && (r_step == '0);
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_step == '0) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_m4   <= i_m4;
            r_n    <= '0;
            r_step <= STEP_W'(MAG_W - 1);
        end else if (r_busy) begin
            if (M4_W'(odd_sq) <= r_m4) begin
                r_n <= trial;
            end
            r_step <= r_step - 1'b1;
        end
    end

    assign o_status.done = r_done;
    assign o_status.mag  = r_n;

endmodule

// ----- src/prewitt_gradient_3x3.sv -----
`timescale 1ns / 1ps
// A pixel that completes a window goes through the load, square, sum, root and done states;
// a pixel that gives none returns to idle after the load state. A new pixel is taken only once
// the one before is through; the 7-step magnitude root and the line store read set the pace.
// Reset (synchronous, active low) clears the counters, the window and the handshake state
// and loads image_width 640 and image_height 480; the line stores keep their contents.

// Prewitt 3x3 edge operator on a raster pixel stream.
//
// One pixel is worked on at a time. The pixel request reads the line store word at the
// current column (older line in the upper half, previous line in the lower half). In the
// next cycle the window shifts left, the new right column is formed from that word and the
// pixel, and the word is written back moved down by one line. Because only one pixel is in
// flight and the write happens before the next read, no forwarding is needed. A pixel with
// a full window then goes through squaring, the sum of squares and the bit-serial root, and
// the result waits in the output register while the next pixel is already taken in.
module prewitt_gradient_3x3
    import pg3_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    // Configuration write port.
    input  logic                i_cfg_wr_en,
    input  logic                i_cfg_addr,
    input  logic [CFG_W-1:0]    i_cfg_wdata,
    // Pixel stream.
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [7:0]          s_axis_tdata,   // [7:0] pixel
    // Result stream.
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [23:0]         m_axis_tdata,   // [7:0] row_diff, [15:8] col_diff,
                                                // [22:16] magnitude, [23] zero
    output logic                m_axis_tlast    // frame_end
);

    t_state r_state, n_state;

    logic [WIDTH_W-1:0]  r_width;
    logic [HEIGHT_W-1:0] r_height;
    logic [COL_W-1:0]    r_col;
    logic [ROW_W-1:0]    r_row;
    logic [PIX_W-1:0]    r_win [9];
    logic [PIX_W-1:0]    n_win [9];
    logic [PIX_W-1:0]    r_pix;
    logic                r_last;
    logic signed [SUM_W-1:0] r_sr, r_sc;
    logic [SQ_W-1:0]     r_sq_r, r_sq_c;
    logic signed [DIFF_W-1:0] r_row_diff, r_col_diff;

    logic                r_out_valid;
    logic [23:0]         r_out_data;
    logic                r_out_last;

    // Control decoded from the state.
    logic                pix_take;
    logic                win_update;
    logic                root_start;
    logic                out_load;

    logic [WIDTH_W-1:0]  width_eff;
    logic [HEIGHT_W-1:0] height_eff;
    logic                line_end;
    logic                last_row;
    logic                emit;

    t_line_word          ram_rd;
    t_line_word          ram_wr;
    t_root_status        root_st;
    logic [M4_W-1:0]     m4;

    logic [9:0]          bot_sum, top_sum, right_sum, left_sum;
    logic signed [SUM_W-1:0] sr, sc;
    logic signed [2*SUM_W-1:0] sq_r_full, sq_c_full;

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:   if (s_axis_tvalid) n_state = ST_LOAD;
            ST_LOAD:   n_state = emit ? ST_SQUARE : ST_IDLE;
            ST_SQUARE: n_state = ST_SUM;
            ST_SUM:    n_state = ST_ROOT;
            ST_ROOT:   if (root_st.done) n_state = ST_DONE;
            ST_DONE:   if (!r_out_valid || m_axis_tready) n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    // Outputs of the state machine.
    always_comb begin
        s_axis_tready = 1'b0;
        win_update    = 1'b0;
        root_start    = 1'b0;
        out_load      = 1'b0;
        case (r_state)
            ST_IDLE:   s_axis_tready = 1'b1;
            ST_LOAD:   win_update    = 1'b1;
            ST_SUM:    root_start    = 1'b1;
            ST_DONE:   out_load      = !r_out_valid || m_axis_tready;
            default:   ;
        endcase
    end

    assign pix_take = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Configuration registers; out-of-range values are clamped where they are used.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= WIDTH_W'(640);
            r_height <= HEIGHT_W'(480);
        end else if (i_cfg_wr_en) begin
            case (i_cfg_addr)
                CFG_IMAGE_WIDTH:  r_width  <= i_cfg_wdata[WIDTH_W-1:0];
                CFG_IMAGE_HEIGHT: r_height <= i_cfg_wdata;
                default:          ;
            endcase
        end
    end

    always_comb begin
        if (r_width < WIDTH_W'(3)) begin
            width_eff = WIDTH_W'(3);
        end else if (r_width > WIDTH_W'(LINE_DEPTH)) begin
            width_eff = WIDTH_W'(LINE_DEPTH);
        end else begin
            width_eff = r_width;
        end
        if (r_height < HEIGHT_W'(3)) begin
            height_eff = HEIGHT_W'(3);
        end else if (r_height > HEIGHT_W'(MAX_HEIGHT)) begin
            height_eff = HEIGHT_W'(MAX_HEIGHT);
        end else begin
            height_eff = r_height;
        end
    end

    // Position flags of the pixel in flight. The counters still hold its position here.
    assign emit     = (r_row >= ROW_W'(2)) && (r_col >= COL_W'(2));
    assign line_end = (WIDTH_W'(r_col) + WIDTH_W'(1)) >= width_eff;
    assign last_row = (HEIGHT_W'(r_row) + HEIGHT_W'(1)) >= height_eff;

    // The line store word read for this column becomes the new right column's top two
    // pixels; the word written back drops the oldest line.
    pg3_line_ram u_line_ram (
        .i_clk     (i_clk),
        .i_rd_en   (pix_take),
        .i_rd_addr (r_col),
        .o_rd_data (ram_rd),
        .i_wr_en   (win_update),
        .i_wr_addr (r_col),
        .i_wr_data (ram_wr)
    );

    assign ram_wr.upper = ram_rd.lower;
    assign ram_wr.lower = r_pix;

    // Window shifted left with the new right column.
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_win[i*3]   = r_win[i*3+1];
            n_win[i*3+1] = r_win[i*3+2];
        end
        n_win[2] = ram_rd.upper;
        n_win[5] = ram_rd.lower;
        n_win[8] = r_pix;
    end

    always_comb begin
        bot_sum   = 10'(n_win[6]) + 10'(n_win[7]) + 10'(n_win[8]);
        top_sum   = 10'(n_win[0]) + 10'(n_win[1]) + 10'(n_win[2]);
        right_sum = 10'(n_win[2]) + 10'(n_win[5]) + 10'(n_win[8]);
        left_sum  = 10'(n_win[0]) + 10'(n_win[3]) + 10'(n_win[6]);
        sr        = $signed({1'b0, bot_sum}) - $signed({1'b0, top_sum});
        sc        = $signed({1'b0, right_sum}) - $signed({1'b0, left_sum});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
            for (int i = 0; i < 9; i++) begin
                r_win[i] <= '0;
            end
        end else if (win_update) begin
            r_win <= n_win;
            if (line_end) begin
                r_col <= '0;
                r_row <= last_row ? '0 : r_row + 1'b1;
            end else begin
                r_col <= r_col + 1'b1;
            end
        end
    end

    // Payload of the pixel in flight.
    always_ff @(posedge i_clk) begin
        if (pix_take) begin
            r_pix <= s_axis_tdata;
        end
        if (win_update) begin
            r_sr   <= sr;
            r_sc   <= sc;
            r_last <= line_end && last_row;
        end
    end

    // Squares and the divided differences.
    assign sq_r_full = r_sr * r_sr;
    assign sq_c_full = r_sc * r_sc;

    always_ff @(posedge i_clk) begin
        if (r_state == ST_SQUARE) begin
            r_sq_r     <= sq_r_full[SQ_W-1:0];
            r_sq_c     <= sq_c_full[SQ_W-1:0];
            r_row_diff <= div3_sat(r_sr);
            r_col_diff <= div3_sat(r_sc);
        end
    end

    // Four times the sum of squares keeps the root search on integers.
    assign m4 = {(M4_W-2)'(r_sq_r) + (M4_W-2)'(r_sq_c), 2'b00};

    pg3_mag_root u_mag_root (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (root_start),
        .i_m4     (m4),
        .o_status (root_st)
    );

    // Output register: holds one finished result while the next pixel is worked on.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_data <= {1'b0, root_st.mag, r_col_diff, r_row_diff};
            r_out_last <= r_last;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tlast  = r_out_last;

endmodule

// ----- src/pg3_checker.sv -----
`timescale 1ns / 1ps

module pg3_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [23:0] m_axis_tdata,
    input logic        m_axis_tlast
);

    // A stalled result stays offered.
    a_out_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result request dropped while stalled");

    // A stalled result keeps its payload.
    a_out_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("result payload changed while stalled");

    // Only one pixel is worked on at a time.
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("pixel taken while another is in flight");

    // A new result is loaded only while the pixel side is busy.
    a_load_when_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> !$past(s_axis_tready))
        else $error("result appeared without a pixel in flight");

    // The magnitude is never below a non-negative row difference.
    a_mag_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tdata[7] |-> m_axis_tdata[22:16] >= m_axis_tdata[6:0])
        else $error("magnitude below row difference");

endmodule

bind prewitt_gradient_3x3 pg3_checker u_pg3_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);
